// ----- design/ahbs_pkg.sv -----
// ----------------------------------------------------------------------------
// ahbs_pkg
// Shared constants and types of the async HDLC byte stuffer.
// ----------------------------------------------------------------------------
package ahbs_pkg;

    localparam logic [7:0] FLAG_BYTE = 8'h7E;
    localparam logic [7:0] ESC_BYTE  = 8'h7D;
    localparam logic [7:0] ESC_XOR   = 8'h20;

    localparam int ACCM_W    = 64;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_ACCM_0 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACCM_1 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ACCM_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ACCM_3 = 2'd3;

    localparam logic [ACCM_W-1:0] ACCM_0_RST = 64'h0000_0000_FFFF_FFFF;
    localparam logic [ACCM_W-1:0] ACCM_1_RST = 64'h6000_0000_0000_0000;
    localparam logic [ACCM_W-1:0] ACCM_2_RST = 64'h0;
    localparam logic [ACCM_W-1:0] ACCM_3_RST = 64'h0;

    localparam int QUEUE_DEPTH_DEF = 2;

    // One classified word handed from front to back
    typedef struct packed {
        logic [7:0] data;
        logic       first;
        logic       last;
        logic       escape;
    } job_t;

    typedef enum logic [3:0] {
        PH_OPEN  = 4'b0001,
        PH_ESC   = 4'b0010,
        PH_DATA  = 4'b0100,
        PH_CLOSE = 4'b1000
    } phase_t;

endpackage

// ----- design/ahbs_front.sv -----
// ----------------------------------------------------------------------------
// ahbs_front
// Holds the escape map and classifies each incoming word.
// ----------------------------------------------------------------------------
module ahbs_front
    import ahbs_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ACCM_W-1:0]    cfg_data,
    input  logic [7:0]           payload_byte,
    input  logic                 frame_first,
    input  logic                 frame_last,
    output job_t                 job
);

    logic [ACCM_W-1:0] accm_0_reg;
    logic [ACCM_W-1:0] accm_1_reg;
    logic [ACCM_W-1:0] accm_2_reg;
    logic [ACCM_W-1:0] accm_3_reg;
    logic [ACCM_W-1:0] map_word;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accm_0_reg <= ACCM_0_RST;
            accm_1_reg <= ACCM_1_RST;
            accm_2_reg <= ACCM_2_RST;
            accm_3_reg <= ACCM_3_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ACCM_0: accm_0_reg <= cfg_data;
                REG_ACCM_1: accm_1_reg <= cfg_data;
                REG_ACCM_2: accm_2_reg <= cfg_data;
                REG_ACCM_3: accm_3_reg <= cfg_data;
                default:    accm_0_reg <= accm_0_reg;
            endcase
        end
    end

    // Pick the map word by the top two bits, then the bit by the rest
    always_comb
    begin
        unique case (payload_byte[7:6])
            2'd0:    map_word = accm_0_reg;
            2'd1:    map_word = accm_1_reg;
            2'd2:    map_word = accm_2_reg;
            default: map_word = accm_3_reg;
        endcase
        job.data   = payload_byte;
        job.first  = frame_first;
        job.last   = frame_last;
        job.escape = map_word[payload_byte[5:0]];
    end

endmodule

// ----- design/ahbs_queue.sv -----
// ----------------------------------------------------------------------------
// ahbs_queue
// Short queue of classified words between front and back.
// ----------------------------------------------------------------------------
module ahbs_queue
    import ahbs_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  job_t wr_job,
    output logic full,
    input  logic rd_en,
    output job_t rd_job,
    output logic rd_valid
);

    localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int COUNT_W = $clog2(DEPTH + 1);

    job_t               slot_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic               do_wr;
    logic               do_rd;

    assign full     = (count_reg == COUNT_W'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_job   = slot_reg[rd_ptr_reg];
    assign do_wr    = wr_en && !full;
    assign do_rd    = rd_en && rd_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_job;
        end
    end

endmodule

// ----- design/ahbs_back.sv -----
// ----------------------------------------------------------------------------
// ahbs_back
// Steps through the line bytes of each word and holds them for the reader.
// ----------------------------------------------------------------------------
module ahbs_back
    import ahbs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  job_t       job,
    input  logic       job_valid,
    output logic       job_take,
    output logic [7:0] line_byte,
    output logic       is_flag,
    output logic       run_last,
    output logic       empty,
    input  logic       pop
);

    phase_t     phase_reg;
    phase_t     phase_next;
    phase_t     cur_phase;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic [7:0] byte_reg;
    logic [7:0] byte_next;
    logic       flag_reg;
    logic       flag_next;
    logic       last_reg;
    logic       last_next;
    logic       advance;
    logic       emit;

    assign advance = !out_valid_reg || pop;
    assign emit    = advance && job_valid;

    always_comb
    begin
        // Skip the phases this word does not need
        unique case (phase_reg)
            PH_OPEN:
            begin
                if (job.first)
                begin
                    cur_phase = PH_OPEN;
                end
                else if (job.escape)
                begin
                    cur_phase = PH_ESC;
                end
                else
                begin
                    cur_phase = PH_DATA;
                end
            end
            PH_ESC:   cur_phase = PH_ESC;
            PH_DATA:  cur_phase = PH_DATA;
            PH_CLOSE: cur_phase = PH_CLOSE;
            default:  cur_phase = PH_OPEN;
        endcase

        byte_next = byte_reg;
        flag_next = flag_reg;
        last_next = last_reg;
        job_take  = 1'b0;

        unique case (cur_phase)
            PH_OPEN:
            begin
                byte_next  = FLAG_BYTE;
                flag_next  = 1'b1;
                last_next  = 1'b0;
                phase_next = job.escape ? PH_ESC : PH_DATA;
            end
            PH_ESC:
            begin
                byte_next  = ESC_BYTE;
                flag_next  = 1'b0;
                last_next  = 1'b0;
                phase_next = PH_DATA;
            end
            PH_DATA:
            begin
                byte_next  = job.escape ? (job.data ^ ESC_XOR) : job.data;
                flag_next  = 1'b0;
                last_next  = !job.last;
                job_take   = emit && !job.last;
                phase_next = job.last ? PH_CLOSE : PH_OPEN;
            end
            PH_CLOSE:
            begin
                byte_next  = FLAG_BYTE;
                flag_next  = 1'b1;
                last_next  = 1'b1;
                job_take   = emit;
                phase_next = PH_OPEN;
            end
            default:
            begin
                phase_next = PH_OPEN;
            end
        endcase

        if (!emit)
        begin
            byte_next  = byte_reg;
            flag_next  = flag_reg;
            last_next  = last_reg;
            phase_next = phase_reg;
        end

        out_valid_next = emit ? 1'b1 : (pop ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_OPEN;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        flag_reg <= flag_next;
        last_reg <= last_next;
    end

    assign line_byte = byte_reg;
    assign is_flag   = flag_reg;
    assign run_last  = last_reg;
    assign empty     = !out_valid_reg;

endmodule

// ----- design/async_hdlc_byte_stuffer.sv -----
// ----------------------------------------------------------------------------
// async_hdlc_byte_stuffer
// PPP async HDLC octet stuffer with a 256-bit escape map.
// ----------------------------------------------------------------------------
// Each payload word produces one to four line bytes: an opening flag if it is
// marked first, 0x7D plus the byte XOR 0x20 if its map bit is set (otherwise
// the byte itself), and a closing flag if it is marked last. The back-end
// sequencer sends one line byte per cycle while a word is queued and its
// output byte is free or being popped; input is taken every cycle while the
// classified-word queue (QUEUE_DEPTH deep) has room, and the sustained rate
// is set by that one-byte-per-cycle output. An accepted word is registered in
// the queue before its line bytes are registered for the reader. Map
// registers are written through cfg_we/cfg_index/cfg_data and take effect
// for words accepted after the write.
// ----------------------------------------------------------------------------
module async_hdlc_byte_stuffer
    import ahbs_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ACCM_W-1:0]    cfg_data,
    input  logic                 push,
    output logic                 full,
    input  logic [7:0]           payload_byte,
    input  logic                 frame_first,
    input  logic                 frame_last,
    input  logic                 pop,
    output logic                 empty,
    output logic [7:0]           line_byte,
    output logic                 is_flag,
    output logic                 run_last
);

    job_t in_job;
    job_t head_job;
    logic head_valid;
    logic head_take;

    ahbs_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .payload_byte (payload_byte),
        .frame_first  (frame_first),
        .frame_last   (frame_last),
        .job          (in_job)
    );

    ahbs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (push),
        .wr_job   (in_job),
        .full     (full),
        .rd_en    (head_take),
        .rd_job   (head_job),
        .rd_valid (head_valid)
    );

    ahbs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job       (head_job),
        .job_valid (head_valid),
        .job_take  (head_take),
        .line_byte (line_byte),
        .is_flag   (is_flag),
        .run_last  (run_last),
        .empty     (empty),
        .pop       (pop)
    );

endmodule

// ----- tb/async_hdlc_byte_stuffer_tb.sv -----
// ----------------------------------------------------------------------------
// async_hdlc_byte_stuffer_tb
// Self-checking bench for the PPP async HDLC octet stuffer.
// ----------------------------------------------------------------------------
// Payload words are fed through the push/full side and line bytes are taken
// through the empty/pop side, both with random gaps. Each accepted word is
// expanded into its line bytes by a local stuffing model that tracks its own
// copy of the escape map. Directed words hit the byte extremes, both flags,
// out-of-order frame marks and the empty and full escape maps. Random frames
// with random content then run under several escape maps.
// ----------------------------------------------------------------------------
module async_hdlc_byte_stuffer_tb;
    import ahbs_pkg::*;

    localparam int QUIET_LIMIT = 2000;

    typedef struct packed {
        logic [7:0] data;
        logic       is_first;
        logic       is_last;
    } payload_word_t;

    typedef struct packed {
        logic [7:0] data;
        logic       flag;
        logic       run_end;
    } line_word_t;

    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index    = REG_ACCM_0;
    logic [ACCM_W-1:0]    cfg_data     = '0;
    logic                 push         = 1'b0;
    logic                 full;
    logic [7:0]           payload_byte = 8'h00;
    logic                 frame_first  = 1'b0;
    logic                 frame_last   = 1'b0;
    logic                 pop          = 1'b0;
    logic                 empty;
    logic [7:0]           line_byte;
    logic                 is_flag;
    logic                 run_last;

    logic [ACCM_W-1:0] esc_map [4] = '{ACCM_0_RST, ACCM_1_RST, ACCM_2_RST, ACCM_3_RST};
    payload_word_t     send_queue [$];
    line_word_t        line_expect [$];
    payload_word_t     sent_word;
    int unsigned       idle_pct     = 25;
    int unsigned       stall_pct    = 25;
    int                fail_count   = 0;
    int                quiet_cycles = 0;

    async_hdlc_byte_stuffer uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .push         (push),
        .full         (full),
        .payload_byte (payload_byte),
        .frame_first  (frame_first),
        .frame_last   (frame_last),
        .pop          (pop),
        .empty        (empty),
        .line_byte    (line_byte),
        .is_flag      (is_flag),
        .run_last     (run_last)
    );

    always #6 clk = ~clk;

    // Expand one payload word into the line bytes it must produce
    function automatic void stuff_word(input payload_word_t w);
        logic [ACCM_W-1:0] map_word;
        line_word_t        run [$];
        map_word = esc_map[w.data[7:6]];
        if (w.is_first)
            run.push_back('{FLAG_BYTE, 1'b1, 1'b0});
        if (map_word[w.data[5:0]])
        begin
            run.push_back('{ESC_BYTE, 1'b0, 1'b0});
            run.push_back('{w.data ^ ESC_XOR, 1'b0, 1'b0});
        end
        else
        begin
            run.push_back('{w.data, 1'b0, 1'b0});
        end
        if (w.is_last)
            run.push_back('{FLAG_BYTE, 1'b1, 1'b0});
        run[run.size() - 1].run_end = 1'b1;
        foreach (run[i])
            line_expect.push_back(run[i]);
    endfunction

    function automatic void check_line_byte();
        line_word_t want;
        if (line_expect.size() == 0)
        begin
            $error("line_byte: expected nothing, actual %h", line_byte);
            fail_count++;
        end
        else
        begin
            want = line_expect.pop_front();
            if (line_byte !== want.data)
            begin
                $error("line_byte: expected %h, actual %h", want.data, line_byte);
                fail_count++;
            end
            if (is_flag !== want.flag)
            begin
                $error("is_flag: expected %b, actual %b", want.flag, is_flag);
                fail_count++;
            end
            if (run_last !== want.run_end)
            begin
                $error("run_last: expected %b, actual %b", want.run_end, run_last);
                fail_count++;
            end
        end
    endfunction

    // Sender: hold the word while full, otherwise advance or idle
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (push && !full)
            begin
                sent_word = send_queue.pop_front();
                stuff_word(sent_word);
            end
            if (!(push && full))
            begin
                if (send_queue.size() != 0 && $urandom_range(99) >= idle_pct)
                begin
                    push         <= 1'b1;
                    payload_byte <= send_queue[0].data;
                    frame_first  <= send_queue[0].is_first;
                    frame_last   <= send_queue[0].is_last;
                end
                else
                begin
                    push <= 1'b0;
                end
            end
        end
    end

    // Receiver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pop && !empty)
                check_line_byte();
            pop <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty)
            || (send_queue.size() == 0 && line_expect.size() == 0))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic void queue_word(input logic [7:0] data, input logic first_mark,
                                       input logic last_mark);
        send_queue.push_back('{data, first_mark, last_mark});
    endfunction

    // Load all four map registers, one per cycle
    task automatic write_maps(input logic [ACCM_W-1:0] m0, input logic [ACCM_W-1:0] m1,
                              input logic [ACCM_W-1:0] m2, input logic [ACCM_W-1:0] m3);
        logic [ACCM_W-1:0]    vals [4];
        logic [CFG_IDX_W-1:0] idx [4];
        vals = '{m0, m1, m2, m3};
        idx  = '{REG_ACCM_0, REG_ACCM_1, REG_ACCM_2, REG_ACCM_3};
        for (int i = 0; i < 4; i++)
        begin
            @(posedge clk);
            cfg_we    <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= vals[i];
            esc_map[idx[i]] = vals[i];
        end
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain();
        while (send_queue.size() != 0 || line_expect.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [7:0] pick_byte();
        logic [7:0] specials [7];
        specials = '{8'h7D, 8'h7E, 8'h00, 8'hFF, 8'h20, 8'h5D, 8'h5E};
        if ($urandom_range(9) < 3)
            return specials[$urandom_range(6)];
        return 8'($urandom);
    endfunction

    // Mostly well-formed frames, some words with random marks
    task automatic queue_random_words(input int count);
        int added;
        int len;
        added = 0;
        while (added < count)
        begin
            if ($urandom_range(9) == 0)
            begin
                queue_word(pick_byte(), 1'($urandom), 1'($urandom));
                added++;
            end
            else
            begin
                len = $urandom_range(1, 8);
                for (int i = 0; i < len; i++)
                    queue_word(pick_byte(), i == 0, i == len - 1);
                added += len;
            end
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Reset map: control characters, 0x7D and 0x7E escaped
        queue_word(8'h00, 1'b1, 1'b1);
        queue_word(8'h1F, 1'b1, 1'b0);
        queue_word(8'h20, 1'b0, 1'b0);
        queue_word(8'h7D, 1'b0, 1'b0);
        queue_word(8'h7E, 1'b0, 1'b0);
        queue_word(8'h7F, 1'b0, 1'b0);
        queue_word(8'hFF, 1'b0, 1'b1);
        queue_word(8'h80, 1'b1, 1'b0);
        queue_word(8'h5E, 1'b1, 1'b0);
        queue_word(8'h5D, 1'b0, 1'b1);
        queue_word(8'h41, 1'b0, 1'b0);
        queue_word(8'hC0, 1'b0, 1'b1);
        drain();

        // Empty map: 0x7E and 0x7D go out raw, no flag mark on the data byte
        write_maps('0, '0, '0, '0);
        queue_word(8'h7E, 1'b1, 1'b1);
        queue_word(8'h7D, 1'b0, 1'b0);
        queue_word(8'h00, 1'b0, 1'b1);
        drain();

        // Full map: every byte escaped
        write_maps('1, '1, '1, '1);
        queue_word(8'h7E, 1'b1, 1'b0);
        queue_word(8'hFF, 1'b0, 1'b0);
        queue_word(8'h00, 1'b0, 1'b0);
        queue_word(8'h20, 1'b0, 1'b1);
        drain();

        for (int ph = 0; ph < 5; ph++)
        begin
            if (ph == 0)
                write_maps(ACCM_0_RST, ACCM_1_RST, ACCM_2_RST, ACCM_3_RST);
            else
                write_maps({$urandom, $urandom}, {$urandom, $urandom},
                           {$urandom, $urandom}, {$urandom, $urandom});
            if (ph == 2)
            begin
                idle_pct  = 0;
                stall_pct = 0;
            end
            queue_random_words(25);
            drain();
            idle_pct  = 25;
            stall_pct = 25;
        end

        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ----- files.f -----
design/ahbs_pkg.sv
design/ahbs_front.sv
design/ahbs_queue.sv
design/ahbs_back.sv
design/async_hdlc_byte_stuffer.sv
tb/async_hdlc_byte_stuffer_tb.sv
